// ===== src/pequ_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pequ_pkg
// Shared types and constants of the priority event queue.
// ----------------------------------------------------------------------------
package pequ_pkg;

  // Field widths of the request and result channels
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned TYPE_W     = 8;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned PURGE_W    = 6;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned TYPE_MAX_W = 16;

  // Configuration port
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  typedef enum logic [1:0] {
    REG_LIFE_A = 2'd0,
    REG_LIFE_B = 2'd1,
    REG_RESYNC = 2'd2
  } reg_idx_e;

  typedef enum logic [CMD_W-1:0] {
    CMD_SEND  = 2'd0,
    CMD_RECV  = 2'd1,
    CMD_PURGE = 2'd2
  } cmd_e;

  // Per-cell control of the FIFO chain
  typedef struct packed {
    logic shift;  // take the neighbor's entry
    logic load;   // take the incoming entry
  } cell_ctrl_t;

endpackage

// ===== src/priority_event_queue_with_latches.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_event_queue_with_latches
// Event queue with a lifecycle latch, a resync latch and an ordinary FIFO.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                fields
//  s_axis    in   s_axis_tvalid/tready     tuser: command; tdata: type, data
//  m_axis    out  m_axis_tvalid/tready     tuser: ok; tdata: type, data,
//                                          purged count, five counters
//  apb       in   psel/penable/pready      three 8-bit type-code registers
//
//  One request per cycle: each request is decoded and applied in the cycle
//  it is accepted, and its result lands in the output register in the cycle
//  after. The FIFO is a chain of cells that shifts toward the head on every
//  receive it serves, so a pop is one step of the chain, not a memory read.
//  s_axis_tready drops only while a result is held and m_axis_tready is
//  low. Reset clears fill count, latch valid bits and counters at once; no
//  clearing pass is needed, the cells hold no valid bits.
// ----------------------------------------------------------------------------
module priority_event_queue_with_latches
  import pequ_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 32,
  parameter int unsigned DATA_BITS  = 64,
  parameter int unsigned TYPE_BITS  = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request: tuser = {command[1:0]}
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [CMD_W-1:0]  s_axis_tuser,
  // tdata = event_type[7:0], event_data[71:8]
  input  logic [71:0]       s_axis_tdata,
  // result: tuser = {ok}
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [0:0]        m_axis_tuser,
  // tdata = out_type[7:0], out_data[71:8], purged_count[77:72],
  // count_enqueued[109:78], count_dropped[141:110], count_purged[173:142],
  // lifecycle_overwrites[205:174], resync_overwrites[237:206], zero[239:238]
  output logic [239:0]      m_axis_tdata,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned ENTRY_BITS = TYPE_BITS + DATA_BITS;
  localparam int unsigned FILL_W     = $clog2(FIFO_DEPTH + 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [TYPE_W-1:0] code_a_q, code_b_q, code_s_q;
  logic              cfg_wr;
  reg_idx_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_a_q <= TYPE_W'(1);
      code_b_q <= TYPE_W'(2);
      code_s_q <= TYPE_W'(3);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_LIFE_A: code_a_q <= pwdata[TYPE_W-1:0];
        REG_LIFE_B: code_b_q <= pwdata[TYPE_W-1:0];
        REG_RESYNC: code_s_q <= pwdata[TYPE_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_LIFE_A: prdata = APB_DW'(code_a_q);
      REG_LIFE_B: prdata = APB_DW'(code_b_q);
      REG_RESYNC: prdata = APB_DW'(code_s_q);
      default:    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  logic                  in_fire;
  logic                  out_valid_q;
  cmd_e                  cmd;
  logic [TYPE_W-1:0]     raw_type;
  logic [TYPE_MAX_W-1:0] type_ext;
  logic [DATA_W-1:0]     raw_data;
  logic [ENTRY_BITS-1:0] new_entry;
  logic                  is_life;
  logic                  is_sync;

  // Accept while the output register is empty or being drained
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign cmd       = cmd_e'(s_axis_tuser);
  assign raw_type  = s_axis_tdata[TYPE_W-1:0];
  assign raw_data  = s_axis_tdata[TYPE_W+DATA_W-1:TYPE_W];
  assign type_ext  = TYPE_MAX_W'(raw_type);
  assign new_entry = {raw_data[DATA_BITS-1:0], type_ext[TYPE_BITS-1:0]};

  // Lifecycle wins when a code matches both latches
  assign is_life = (raw_type == code_a_q) || (raw_type == code_b_q);
  assign is_sync = !is_life && (raw_type == code_s_q);

  // --------------------------------------------------------------------------
  // Latches, FIFO chain and counters
  // --------------------------------------------------------------------------
  logic                  life_valid_q, life_valid_d;
  logic                  sync_valid_q, sync_valid_d;
  logic [ENTRY_BITS-1:0] life_entry_q, life_entry_d;
  logic [ENTRY_BITS-1:0] sync_entry_q, sync_entry_d;
  logic [CNT_W-1:0]      cnt_enq_q,  cnt_enq_d;
  logic [CNT_W-1:0]      cnt_drop_q, cnt_drop_d;
  logic [CNT_W-1:0]      cnt_purg_q, cnt_purg_d;
  logic [CNT_W-1:0]      cnt_life_q, cnt_life_d;
  logic [CNT_W-1:0]      cnt_sync_q, cnt_sync_d;

  logic                  fifo_push, fifo_pop, fifo_clear, fifo_full;
  logic [ENTRY_BITS-1:0] fifo_head;
  logic [FILL_W-1:0]     fifo_fill;
  logic [CNT_W-1:0]      fill_wide;

  logic                  res_ok_d,    res_ok_q;
  logic [TYPE_W-1:0]     res_type_d,  res_type_q;
  logic [DATA_W-1:0]     res_data_d,  res_data_q;
  logic [PURGE_W-1:0]    res_purge_d, res_purge_q;

  assign fill_wide = CNT_W'(fifo_fill);

  pequ_chain #(
    .DEPTH     (FIFO_DEPTH),
    .ENTRY_BITS(ENTRY_BITS)
  ) u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fifo_push),
    .pop_i  (fifo_pop),
    .clear_i(fifo_clear),
    .entry_i(new_entry),
    .head_o (fifo_head),
    .fill_o (fifo_fill),
    .full_o (fifo_full)
  );

  always_comb begin
    life_valid_d = life_valid_q;
    sync_valid_d = sync_valid_q;
    life_entry_d = life_entry_q;
    sync_entry_d = sync_entry_q;
    cnt_enq_d    = cnt_enq_q;
    cnt_drop_d   = cnt_drop_q;
    cnt_purg_d   = cnt_purg_q;
    cnt_life_d   = cnt_life_q;
    cnt_sync_d   = cnt_sync_q;
    fifo_push    = 1'b0;
    fifo_pop     = 1'b0;
    fifo_clear   = 1'b0;
    res_ok_d     = 1'b0;
    res_type_d   = '0;
    res_data_d   = '0;
    res_purge_d  = '0;
    if (in_fire) begin
      unique case (cmd)
        CMD_SEND: begin
          res_ok_d = 1'b1;
          if (is_life) begin
            // overwrite a pending lifecycle event and count it
            if (life_valid_q) cnt_life_d = cnt_life_q + CNT_W'(1);
            life_entry_d = new_entry;
            life_valid_d = 1'b1;
          end else if (is_sync) begin
            if (sync_valid_q) cnt_sync_d = cnt_sync_q + CNT_W'(1);
            sync_entry_d = new_entry;
            sync_valid_d = 1'b1;
          end else if (!fifo_full) begin
            fifo_push = 1'b1;
            cnt_enq_d = cnt_enq_q + CNT_W'(1);
          end else begin
            // FIFO full: drop the event
            res_ok_d   = 1'b0;
            cnt_drop_d = cnt_drop_q + CNT_W'(1);
          end
        end
        CMD_RECV: begin
          if (life_valid_q) begin
            life_valid_d = 1'b0;
            res_ok_d     = 1'b1;
            res_type_d   = TYPE_W'(life_entry_q[TYPE_BITS-1:0]);
            res_data_d   = DATA_W'(life_entry_q[ENTRY_BITS-1:TYPE_BITS]);
          end else if (sync_valid_q) begin
            sync_valid_d = 1'b0;
            res_ok_d     = 1'b1;
            res_type_d   = TYPE_W'(sync_entry_q[TYPE_BITS-1:0]);
            res_data_d   = DATA_W'(sync_entry_q[ENTRY_BITS-1:TYPE_BITS]);
          end else if (fifo_fill != '0) begin
            fifo_pop   = 1'b1;
            res_ok_d   = 1'b1;
            res_type_d = TYPE_W'(fifo_head[TYPE_BITS-1:0]);
            res_data_d = DATA_W'(fifo_head[ENTRY_BITS-1:TYPE_BITS]);
          end
        end
        CMD_PURGE: begin
          fifo_clear  = 1'b1;
          res_purge_d = fill_wide[PURGE_W-1:0];
          cnt_purg_d  = cnt_purg_q + fill_wide;
        end
        default: ;  // unused code: report unchanged state
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      life_valid_q <= 1'b0;
      sync_valid_q <= 1'b0;
      cnt_enq_q    <= '0;
      cnt_drop_q   <= '0;
      cnt_purg_q   <= '0;
      cnt_life_q   <= '0;
      cnt_sync_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      life_valid_q <= life_valid_d;
      sync_valid_q <= sync_valid_d;
      cnt_enq_q    <= cnt_enq_d;
      cnt_drop_q   <= cnt_drop_d;
      cnt_purg_q   <= cnt_purg_d;
      cnt_life_q   <= cnt_life_d;
      cnt_sync_q   <= cnt_sync_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Latch and result payload: no reset
  always_ff @(posedge clk_i) begin
    life_entry_q <= life_entry_d;
    sync_entry_q <= sync_entry_d;
    if (in_fire) begin
      res_ok_q    <= res_ok_d;
      res_type_q  <= res_type_d;
      res_data_q  <= res_data_d;
      res_purge_q <= res_purge_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result channel; counters stay put while a result is held
  // --------------------------------------------------------------------------
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_ok_q;
  assign m_axis_tdata  = {2'b00, cnt_sync_q, cnt_life_q, cnt_purg_q, cnt_drop_q,
                          cnt_enq_q, res_purge_q, res_data_q, res_type_q};

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_fill <= FILL_W'(FIFO_DEPTH))
    else $error("FIFO fill beyond depth");

  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |-> !s_axis_tready)
    else $error("request accepted while result stalled");

  a_purge_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && cmd == CMD_PURGE |=> fifo_fill == '0)
    else $error("FIFO not empty after purge");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> m_axis_tvalid)
    else $error("no result after accepted request");
`endif

endmodule

// ===== src/pequ_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pequ_cell
// One storage cell of the FIFO chain: shifts toward the head or loads.
// ----------------------------------------------------------------------------
module pequ_cell
  import pequ_pkg::*;
#(
  parameter int unsigned ENTRY_BITS = 72
) (
  input  logic                  clk_i,
  input  cell_ctrl_t            ctrl_i,
  input  logic [ENTRY_BITS-1:0] nbr_i,
  input  logic [ENTRY_BITS-1:0] new_i,
  output logic [ENTRY_BITS-1:0] entry_o
);

  logic [ENTRY_BITS-1:0] entry_q;
  logic [ENTRY_BITS-1:0] entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift) begin
      entry_d = nbr_i;
    end else if (ctrl_i.load) begin
      entry_d = new_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== src/pequ_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pequ_chain
// Ordinary-event FIFO built as a chain of cells; cell 0 is the head.
// ----------------------------------------------------------------------------
module pequ_chain
  import pequ_pkg::*;
#(
  parameter int unsigned DEPTH      = 32,
  parameter int unsigned ENTRY_BITS = 72,
  localparam int unsigned FILL_W    = $clog2(DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic                  pop_i,
  input  logic                  clear_i,
  input  logic [ENTRY_BITS-1:0] entry_i,
  output logic [ENTRY_BITS-1:0] head_o,
  output logic [FILL_W-1:0]     fill_o,
  output logic                  full_o
);

  logic [FILL_W-1:0]     fill_q;
  logic [FILL_W-1:0]     fill_d;
  logic [ENTRY_BITS-1:0] cell_q [DEPTH];

  always_comb begin
    fill_d = fill_q;
    if (clear_i) begin
      fill_d = '0;
    end else if (push_i) begin
      fill_d = fill_q + FILL_W'(1);
    end else if (pop_i) begin
      fill_d = fill_q - FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctrl_t            ctrl;
    logic [ENTRY_BITS-1:0] nbr;

    assign ctrl.shift = pop_i;
    assign ctrl.load  = push_i && (fill_q == FILL_W'(i));

    if (i == DEPTH - 1) begin : g_tail
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end

    pequ_cell #(
      .ENTRY_BITS(ENTRY_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .nbr_i  (nbr),
      .new_i  (entry_i),
      .entry_o(cell_q[i])
    );
  end

  assign head_o = cell_q[0];
  assign fill_o = fill_q;
  assign full_o = (fill_q == FILL_W'(DEPTH));

endmodule
